FILE: rtl/pvoa_pkg.sv
// shared types, widths and the arctangent table for the proximity vector avoider
package pvoa_pkg;

  localparam int XY_W     = 36;
  localparam int Z_W      = 34;
  localparam int SUM_W    = 20;
  localparam int MUL_A_W  = 36;
  localparam int MUL_B_W  = 20;
  localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
  localparam int MAG_W    = 36;
  localparam int ATAN_IDX_W = 5;
  localparam int ANG_W    = 17;

  localparam logic [1:0] REG_CONE_HALF_WIDTH = 2'd0;
  localparam logic [1:0] REG_NEAR_THRESHOLD  = 2'd1;
  localparam logic [1:0] REG_WHEEL_SPEED     = 2'd2;

  localparam logic [14:0] CONE_RESET  = 15'd1820;
  localparam logic [13:0] THR_RESET   = 14'd2048;
  localparam logic [15:0] SPEED_RESET = 16'd250;

  localparam logic signed [MUL_B_W-1:0] GAIN_INV = 20'sd39797;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ROT,
    S_GAINX,
    S_GAINY,
    S_ACC,
    S_VEC,
    S_VWAIT,
    S_SQX,
    S_SQY,
    S_LIM,
    S_LIMSQ,
    S_DECIDE
  } state_t;

  typedef struct packed {
    logic start;
    logic vectoring;
  } cordic_ctl_t;

  function automatic logic [31:0] atan_lookup(input logic [ATAN_IDX_W-1:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2FA;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A30;
      5'd19:   v = 32'h00000518;
      5'd20:   v = 32'h0000028C;
      5'd21:   v = 32'h00000146;
      5'd22:   v = 32'h000000A3;
      5'd23:   v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/pvoa_cordic.sv
// iterative cordic, one micro-rotation per cycle, rotation or vectoring mode
module pvoa_cordic
  import pvoa_pkg::*;
#(
  parameter int STEPS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cordic_ctl_t             ctl,
  input  logic signed [XY_W-1:0]  x_init,
  input  logic signed [XY_W-1:0]  y_init,
  input  logic signed [Z_W-1:0]   z_init,
  output logic                    done,
  output logic signed [XY_W-1:0]  x_out,
  output logic signed [XY_W-1:0]  y_out,
  output logic signed [Z_W-1:0]   z_out
);

  localparam int IDX_W = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic                   busy_r;
  logic                   done_r;
  logic                   vec_r;
  logic [IDX_W-1:0]       idx_r;
  logic signed [XY_W-1:0] x_r;
  logic signed [XY_W-1:0] y_r;
  logic signed [Z_W-1:0]  z_r;

  logic signed [XY_W-1:0] dx;
  logic signed [XY_W-1:0] dy;
  logic signed [Z_W-1:0]  dz;
  logic                   dir_neg;

  always_comb begin
    dx = y_r >>> idx_r;
    dy = x_r >>> idx_r;
    dz = $signed(Z_W'(atan_lookup(ATAN_IDX_W'(idx_r))));
    dir_neg = vec_r ? (y_r <= 0) : (z_r >= 0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
      end else if (busy_r) begin
        idx_r <= idx_r + 1'b1;
        if (idx_r == IDX_W'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      vec_r <= ctl.vectoring;
      x_r   <= x_init;
      y_r   <= y_init;
      z_r   <= z_init;
    end else if (busy_r) begin
      if (dir_neg) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - dz;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + dz;
      end
    end
  end

  assign done  = done_r;
  assign x_out = x_r;
  assign y_out = y_r;
  assign z_out = z_r;

endmodule

FILE: rtl/proximity_vector_obstacle_avoider_core.sv
// Proximity readings arrive one transaction at a time; each is rotated into x/y by
// an iterative CORDIC and scaled by the gain inverse on one shared multiplier, and
// in_tready stays low at least until the reading is added to the sum. A reading with
// tlast adds a second CORDIC pass in vectoring mode for the bearing of the sum plus
// four multiplier steps for the length test; the vectoring pass is skipped when the
// sum is zero. Readings beyond MAX_READINGS in one control step are ignored apart
// from their tlast. The result waits in an output register, and the next reading is
// taken while it is pending; a later decision holds in its last step until that
// result has been taken.
module proximity_vector_obstacle_avoider_core
  import pvoa_pkg::*;
#(
  parameter int MAX_READINGS = 8,
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // prox_value[11:0], sensor_bearing[27:12], zero pad
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // left_speed[15:0], right_speed[31:16]
  output logic        out_tuser,  // going_straight
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_READINGS + 1);

  state_t state_r, state_nxt;

  logic [14:0] cone_r;
  logic [13:0] thr_r;
  logic [15:0] speed_r;

  logic signed [SUM_W-1:0] sum_x_r;
  logic signed [SUM_W-1:0] sum_y_r;
  logic [CNT_W-1:0]        count_r;
  logic                    last_r;
  logic                    flip_r;
  logic signed [SUM_W-1:0] px_r;
  logic signed [MUL_P_W-1:0] mul_r;
  logic [MAG_W-1:0]        mag_r;
  logic signed [ANG_W-1:0] ang_r;

  logic        out_valid_r;
  logic [31:0] out_data_r;
  logic        out_user_r;

  cordic_ctl_t            cor_ctl;
  logic signed [XY_W-1:0] cor_x_init;
  logic signed [XY_W-1:0] cor_y_init;
  logic signed [Z_W-1:0]  cor_z_init;
  logic                   cor_done;
  logic signed [XY_W-1:0] cor_x;
  logic signed [XY_W-1:0] cor_y;
  logic signed [Z_W-1:0]  cor_z;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;

  logic                    in_fire;
  logic                    room;
  logic                    out_free;
  logic [11:0]             in_prox;
  logic signed [16:0]      bear17;
  logic signed [16:0]      bear_fold;
  logic                    bear_flip;
  logic                    sum_zero;
  logic signed [Z_W-1:0]   z_round;
  logic [15:0]             ang_u;
  logic signed [ANG_W-1:0] ang_calc;
  logic signed [ANG_W-1:0] alpha;
  logic                    in_cone;
  logic                    near_ok;
  logic                    straight;
  logic                    positive;
  logic signed [SUM_W-1:0] lim;

  pvoa_cordic #(
    .STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (cor_ctl),
    .x_init (cor_x_init),
    .y_init (cor_y_init),
    .z_init (cor_z_init),
    .done   (cor_done),
    .x_out  (cor_x),
    .y_out  (cor_y),
    .z_out  (cor_z)
  );

  function automatic logic signed [SUM_W-1:0] gain_round(input logic signed [MUL_P_W-1:0] p);
    logic signed [MUL_P_W:0] t;
    t = (MUL_P_W + 1)'(p) + $signed((MUL_P_W + 1)'(33'h080000000));
    return t[SUM_W+31:32];
  endfunction

  // fold bearing into plus or minus a quarter turn
  always_comb begin
    in_prox   = in_tdata[11:0];
    bear17    = $signed({in_tdata[27], in_tdata[27:12]});
    bear_fold = bear17;
    bear_flip = 1'b0;
    if (bear17 > 17'sd16384) begin
      bear_fold = bear17 - 17'sd32768;
      bear_flip = 1'b1;
    end else if (bear17 < -17'sd16384) begin
      bear_fold = bear17 + 17'sd32768;
      bear_flip = 1'b1;
    end
  end

  always_comb begin
    sum_zero = (sum_x_r == '0) && (sum_y_r == '0);
    z_round  = cor_z + $signed(Z_W'(32768));
    ang_u    = z_round[31:16];
    ang_calc = $signed({ang_u[15], ang_u});
    if (ang_u == 16'h8000 && !sum_y_r[SUM_W-1]) begin
      ang_calc = 17'sd32768;
    end
    alpha    = $signed({2'b00, cone_r});
    in_cone  = (ang_r >= -alpha) && (ang_r <= alpha);
    near_ok  = ({2'b00, mag_r, 2'b00} < 40'(mul_r[39:0]));
    straight = in_cone && near_ok;
    positive = (sum_y_r > 0) || ((sum_y_r == 0) && (sum_x_r < 0));
    lim      = mul_r[SUM_W-1:0];
  end

  always_comb begin
    room     = (count_r < CNT_W'(MAX_READINGS));
    out_free = !out_valid_r || out_tready;
    in_tready = (state_r == S_IDLE);
    in_fire  = in_tvalid && in_tready;

    state_nxt     = state_r;
    cor_ctl.start = 1'b0;
    cor_ctl.vectoring = 1'b0;
    cor_x_init = $signed(XY_W'({in_prox, 16'h0000}));
    cor_y_init = '0;
    cor_z_init = $signed({bear_fold[16], bear_fold, 16'h0000});
    mul_a = '0;
    mul_b = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (room) begin
            cor_ctl.start = 1'b1;
            state_nxt = S_ROT;
          end else if (in_tlast) begin
            state_nxt = S_VEC;
          end
        end
      end
      S_ROT: begin
        if (cor_done) begin
          state_nxt = S_GAINX;
        end
      end
      S_GAINX: begin
        mul_a = flip_r ? -cor_x : cor_x;
        mul_b = GAIN_INV;
        state_nxt = S_GAINY;
      end
      S_GAINY: begin
        mul_a = flip_r ? -cor_y : cor_y;
        mul_b = GAIN_INV;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        state_nxt = last_r ? S_VEC : S_IDLE;
      end
      S_VEC: begin
        cor_ctl.vectoring = 1'b1;
        if (sum_x_r < 0) begin
          cor_x_init = -$signed({sum_x_r, 16'h0000});
          cor_y_init = -$signed({sum_y_r, 16'h0000});
          cor_z_init = $signed(Z_W'(33'h080000000));
        end else begin
          cor_x_init = $signed({sum_x_r, 16'h0000});
          cor_y_init = $signed({sum_y_r, 16'h0000});
          cor_z_init = '0;
        end
        if (sum_zero) begin
          state_nxt = S_SQX;
        end else begin
          cor_ctl.start = 1'b1;
          state_nxt = S_VWAIT;
        end
      end
      S_VWAIT: begin
        if (cor_done) begin
          state_nxt = S_SQX;
        end
      end
      S_SQX: begin
        mul_a = MUL_A_W'(sum_x_r);
        mul_b = sum_x_r;
        state_nxt = S_SQY;
      end
      S_SQY: begin
        mul_a = MUL_A_W'(sum_y_r);
        mul_b = sum_y_r;
        state_nxt = S_LIM;
      end
      S_LIM: begin
        mul_a = $signed(MUL_A_W'(thr_r));
        mul_b = $signed(MUL_B_W'(count_r));
        state_nxt = S_LIMSQ;
      end
      S_LIMSQ: begin
        mul_a = MUL_A_W'(lim);
        mul_b = lim;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cone_r  <= CONE_RESET;
      thr_r   <= THR_RESET;
      speed_r <= SPEED_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_CONE_HALF_WIDTH: cone_r  <= cfg_wdata[14:0];
        REG_NEAR_THRESHOLD:  thr_r   <= cfg_wdata[13:0];
        REG_WHEEL_SPEED:     speed_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // vector sum and reading count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_x_r <= '0;
      sum_y_r <= '0;
      count_r <= '0;
    end else if (state_r == S_ACC) begin
      sum_x_r <= sum_x_r + px_r;
      sum_y_r <= sum_y_r + gain_round(mul_r);
      count_r <= count_r + 1'b1;
    end else if (state_r == S_DECIDE && out_free) begin
      sum_x_r <= '0;
      sum_y_r <= '0;
      count_r <= '0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state_r != S_DECIDE) begin
      mul_r <= mul_a * mul_b;
    end
    if (in_fire) begin
      last_r <= in_tlast;
      flip_r <= bear_flip;
    end
    if (state_r == S_GAINY) begin
      px_r <= gain_round(mul_r);
    end
    if (state_r == S_VEC) begin
      ang_r <= '0;
    end else if (state_r == S_VWAIT && cor_done) begin
      ang_r <= ang_calc;
    end
    if (state_r == S_SQY) begin
      mag_r <= mul_r[MAG_W-1:0];
    end else if (state_r == S_LIM) begin
      mag_r <= mag_r + mul_r[MAG_W-1:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DECIDE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DECIDE && out_free) begin
      if (straight) begin
        out_data_r <= {speed_r, speed_r};
        out_user_r <= 1'b1;
      end else if (positive) begin
        out_data_r <= {16'h0000, speed_r};
        out_user_r <= 1'b0;
      end else begin
        out_data_r <= {speed_r, 16'h0000};
        out_user_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
